// ----- rtl/core/tun_pkg.sv -----
// Shared widths and constants for the triangle unit normal pipeline.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int COORD_W    = 16;
    localparam int EDGE_W     = 17;
    localparam int PROD_W     = 34;
    localparam int CROSS_W    = 35;
    localparam int SQ_W       = 70;
    localparam int SUM_W      = 72;
    localparam int ROOT_W     = 36;
    localparam int REM_W      = 73;
    localparam int Q_W        = 17;
    localparam int NUM_W      = 53;
    localparam int DEN_W      = 37;
    localparam int NORM_W     = 18;
    localparam int CFG_W      = 32;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 56;
    localparam int FRONT_ST   = 7;
    localparam int PIPE_ST    = FRONT_ST + ROOT_W + 1 + Q_W;
    localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 32'd1;
    localparam logic [Q_W-1:0]   ONE_Q16          = 17'd65536;
endpackage

// ----- rtl/core/triangle_unit_normal.sv -----
`timescale 1ns / 1ps
// Unit face normal of a triangle given as three Q8.8 vertices.
//
// Input channel s_axis: one triangle per transfer, nine signed Q8.8 coordinates.
// Output channel m_axis: one result per triangle, in order; tdata carries the
// three Q1.16 components, tuser the normal_ok flag (0 = degenerate, all zero).
// Config: i_cfg_wr_en writes min_length (Q16.16); write only while idle.
//
// Throughput: one triangle per cycle while the receiver does not stall. The
// depth is set by the square root (one root bit per stage, 36 stages) and the
// divider (one quotient bit per stage, 17 stages), plus the edge, cross product
// and squaring stages in front.
//
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and sets min_length
// to 1.
module triangle_unit_normal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
    input  logic [tun_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // normal_x, normal_y, normal_z (18 bits each), 2 zero bits
    output logic [tun_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // normal_ok
    output logic [0:0]  m_axis_tuser
);
    localparam int EW  = tun_pkg::EDGE_W;
    localparam int PW  = tun_pkg::PROD_W;
    localparam int CW  = tun_pkg::CROSS_W;
    localparam int RW  = tun_pkg::ROOT_W;
    localparam int MW  = tun_pkg::REM_W;
    localparam int QW  = tun_pkg::Q_W;
    localparam int NW  = tun_pkg::NUM_W;
    localparam int DW  = tun_pkg::DEN_W;
    localparam int OW  = tun_pkg::NORM_W;
    localparam int NST = tun_pkg::PIPE_ST;

    function automatic logic signed [16:0] f_edge(input logic [15:0] a, input logic [15:0] b);
        f_edge = $signed({b[15], b}) - $signed({a[15], a});
    endfunction

    logic                   w_adv;
    logic [31:0]            r_min_length;
    logic [NST-1:0]         r_vld;
    logic                   r_out_vld;

    logic signed [EW-1:0]   r_e0 [0:2];
    logic signed [EW-1:0]   r_e1 [0:2];
    logic signed [PW-1:0]   r_p  [0:5];
    logic signed [CW-1:0]   r_n  [0:2];
    logic [CW-1:0]          r_mag4 [0:2];
    logic [2:0]             r_neg4;
    logic [33:0]            r_hh [0:2];
    logic [34:0]            r_hl [0:2];
    logic [35:0]            r_ll [0:2];
    logic [CW-1:0]          r_mag5 [0:2];
    logic [2:0]             r_neg5;
    logic [tun_pkg::SQ_W-1:0] r_sq [0:2];
    logic [CW-1:0]          r_mag6 [0:2];
    logic [2:0]             r_neg6;

    logic [RW-1:0]          r_rt  [0:RW];
    logic [MW-1:0]          r_rm  [0:RW];
    logic [CW-1:0]          r_qm  [0:RW][0:2];
    logic [2:0]             r_qn  [0:RW];

    logic [NW-1:0]          r_dr  [0:QW][0:2];
    logic [QW-1:0]          r_dq  [0:QW][0:2];
    logic [DW-1:0]          r_dd  [0:QW];
    logic                   r_dok [0:QW];
    logic [2:0]             r_dn  [0:QW];

    logic [OW-1:0]          r_out [0:2];
    logic                   r_out_ok;
    logic [RW-1:0]          w_len;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_len         = r_rt[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= tun_pkg::MIN_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    // Edges, cross product, magnitudes, squares and their sum.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_e0[c] <= f_edge(s_axis_tdata[16*c +: 16], s_axis_tdata[48 + 16*c +: 16]);
                r_e1[c] <= f_edge(s_axis_tdata[16*c +: 16], s_axis_tdata[96 + 16*c +: 16]);
            end
            r_p[0] <= r_e0[1] * r_e1[2];
            r_p[1] <= r_e0[2] * r_e1[1];
            r_p[2] <= r_e0[2] * r_e1[0];
            r_p[3] <= r_e0[0] * r_e1[2];
            r_p[4] <= r_e0[0] * r_e1[1];
            r_p[5] <= r_e0[1] * r_e1[0];
            for (int c = 0; c < 3; c++) begin
                r_n[c] <= CW'(r_p[2*c]) - CW'(r_p[2*c+1]);
                r_neg4[c] <= r_n[c][CW-1];
                r_mag4[c] <= r_n[c][CW-1] ? CW'(-r_n[c]) : CW'(r_n[c]);
                r_hh[c] <= r_mag4[c][34:18] * r_mag4[c][34:18];
                r_hl[c] <= r_mag4[c][34:18] * r_mag4[c][17:0];
                r_ll[c] <= r_mag4[c][17:0] * r_mag4[c][17:0];
                r_sq[c] <= {r_hh[c], 36'b0} + ({35'b0, r_hl[c]} << 19) + {34'b0, r_ll[c]};
                r_mag5[c] <= r_mag4[c];
                r_mag6[c] <= r_mag5[c];
                r_qm[0][c] <= r_mag6[c];
            end
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
            r_qn[0] <= r_neg6;
            r_rt[0] <= '0;
            r_rm[0] <= MW'({2'b0, r_sq[0]}) + MW'({2'b0, r_sq[1]}) + MW'({2'b0, r_sq[2]});
        end
    end

    // Floor square root, one root bit per stage.
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [MW-1:0] w_sub;
        assign w_sub = (MW'(r_rt[k]) << (B + 1)) | (MW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_rm[k] >= w_sub) begin
                    r_rm[k+1] <= r_rm[k] - w_sub;
                    r_rt[k+1] <= r_rt[k] | (RW'(1) << B);
                end else begin
                    r_rm[k+1] <= r_rm[k];
                    r_rt[k+1] <= r_rt[k];
                end
                for (int c = 0; c < 3; c++) begin
                    r_qm[k+1][c] <= r_qm[k][c];
                end
                r_qn[k+1] <= r_qn[k];
            end
        end
    end

    // Divider setup: numerator m*2^17 + len over 2*len gives the rounded ratio.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dok[0] <= w_len > RW'(r_min_length);
            r_dd[0]  <= {w_len, 1'b0};
            r_dn[0]  <= r_qn[RW];
            for (int c = 0; c < 3; c++) begin
                r_dr[0][c] <= NW'({r_qm[RW][c], 17'b0}) + NW'(w_len);
                r_dq[0][c] <= '0;
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int I = QW - 1 - j;
        logic [NW-1:0] w_cmp;
        assign w_cmp = NW'(r_dd[j]) << I;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_dr[j][c] >= w_cmp) begin
                        r_dr[j+1][c] <= r_dr[j][c] - w_cmp;
                        r_dq[j+1][c] <= r_dq[j][c] | (QW'(1) << I);
                    end else begin
                        r_dr[j+1][c] <= r_dr[j][c];
                        r_dq[j+1][c] <= r_dq[j][c];
                    end
                end
                r_dd[j+1]  <= r_dd[j];
                r_dok[j+1] <= r_dok[j];
                r_dn[j+1]  <= r_dn[j];
            end
        end
    end

    // Saturate, restore the sign, zero degenerate triangles.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                logic [QW-1:0] v_sat;
                v_sat = (r_dq[QW][c] > tun_pkg::ONE_Q16) ? tun_pkg::ONE_Q16 : r_dq[QW][c];
                if (!r_dok[QW]) begin
                    r_out[c] <= '0;
                end else if (r_dn[QW][c]) begin
                    r_out[c] <= OW'(-{1'b0, v_sat});
                end else begin
                    r_out[c] <= {1'b0, v_sat};
                end
            end
            r_out_ok <= r_dok[QW];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b0, r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_out_ok;
endmodule

// ----- rtl/core/tun_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the triangle unit normal block, with its bind.
module tun_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [tun_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("tvalid set after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("tready does not follow output stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result not zero");

    a_unit_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) <= 18'sd65536 &&
                           $signed(m_axis_tdata[17:0]) >= -18'sd65536))
        else $error("normal_x out of range");
endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/tb_triangle_unit_normal.sv -----
`timescale 1ns / 1ps
// Testbench for triangle_unit_normal: random and directed triangles checked against a predictor.

class normal_scoreboard;
    logic [54:0] pending_q[$];   // {ok, z, y, x}
    logic [31:0] min_length;
    int errors;
    int n_checked;
    int n_degenerate;

    function new();
        min_length = tun_pkg::MIN_LENGTH_RESET;
        errors = 0;
        n_checked = 0;
        n_degenerate = 0;
    endfunction

    // round(c * 65536 / len), ties away from zero, saturated to +-1.0
    function logic [17:0] unit_part(logic signed [36:0] c, logic [35:0] len);
        logic [36:0] mag;
        logic [63:0] q;
        mag = c < 0 ? -c : c;
        q = ((64'(mag) << 17) + 64'(len)) / (64'(len) << 1);
        if (q > 64'd65536) q = 64'd65536;
        if (c < 0) q = -q;
        return q[17:0];
    endfunction

    function logic [35:0] floor_root(logic [71:0] v);
        logic [35:0] r;
        logic [35:0] t;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            t = r | (36'd1 << b);
            if (72'(t) * 72'(t) <= v) r = t;
        end
        return r;
    endfunction

    function void note_triangle(logic [143:0] d);
        logic signed [36:0] p[9];
        logic signed [36:0] e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz;
        logic [71:0] sq;
        logic [35:0] len;
        for (int i = 0; i < 9; i++) p[i] = 37'(signed'(d[16*i +: 16]));
        e0x = p[3] - p[0]; e0y = p[4] - p[1]; e0z = p[5] - p[2];
        e1x = p[6] - p[0]; e1y = p[7] - p[1]; e1z = p[8] - p[2];
        nx = e0y * e1z - e0z * e1y;
        ny = e0z * e1x - e0x * e1z;
        nz = e0x * e1y - e0y * e1x;
        sq = 72'(nx) * 72'(nx) + 72'(ny) * 72'(ny) + 72'(nz) * 72'(nz);
        len = floor_root(sq);
        if (len <= 36'(min_length))
            pending_q.push_back('0);
        else
            pending_q.push_back({1'b1, unit_part(nz, len), unit_part(ny, len),
                                 unit_part(nx, len)});
    endfunction

    function void check_result(logic [55:0] data, logic ok);
        logic [54:0] exp_v;
        logic [54:0] got;
        got = {ok, data[53:0]};
        if (pending_q.size() == 0) begin
            $display("%0t: result with nothing pending: %h", $time, got);
            errors++;
            return;
        end
        exp_v = pending_q.pop_front();
        n_checked++;
        if (!exp_v[54]) n_degenerate++;
        for (int f = 0; f < 3; f++)
            if (got[18*f +: 18] != exp_v[18*f +: 18]) begin
                $display("%0t: component %0d expected %0d actual %0d", $time, f,
                         signed'(exp_v[18*f +: 18]), signed'(got[18*f +: 18]));
                errors++;
            end
        if (got[54] != exp_v[54]) begin
            $display("%0t: ok flag expected %0b actual %0b", $time, exp_v[54], got[54]);
            errors++;
        end
        if (data[55:54] != 2'b00) begin
            $display("%0t: pad bits expected 0 actual %b", $time, data[55:54]);
            errors++;
        end
    endfunction
endclass

module tb_triangle_unit_normal;
    localparam int LATENCY = 62;
    localparam int STALL_LIMIT = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [31:0]  i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    int n_sent = 0;
    bit timed_out = 0;
    normal_scoreboard normals = new();

    triangle_unit_normal u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: check each result transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            normals.check_result(m_axis_tdata, m_axis_tuser[0]);
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_triangle_unit_normal: done, errors");
            $finish;
        end
    end

    task automatic send_triangle(input logic [143:0] tri_data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tri_data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        normals.note_triangle(tri_data);
        n_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (normals.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_min_length(input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        normals.min_length = value;
        @(posedge i_clk);
    endtask

    function automatic logic [143:0] pack_tri(input logic [15:0] v[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = v[i];
        return d;
    endfunction

    // Mostly small offsets around a random base vertex, sometimes fully random.
    function automatic logic [143:0] random_tri();
        logic [15:0] v[9];
        int spread;
        spread = 1 << $urandom_range(15, 1);
        for (int i = 0; i < 3; i++) v[i] = 16'($urandom);
        for (int i = 3; i < 9; i++)
            v[i] = ($urandom_range(9) == 0) ? 16'($urandom)
                   : v[i % 3] + 16'($urandom_range(spread - 1)) - 16'(spread / 2);
        if ($urandom_range(19) == 0)   // collinear: C = A + 2(B - A)
            for (int i = 6; i < 9; i++) v[i] = v[i - 3] + v[i - 3] - v[i - 6];
        return pack_tri(v);
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_triangle(random_tri());
    endtask

    initial begin
        logic [15:0] v[9];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset threshold, extremes, degenerate and axis-aligned cases.
        v = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
              16'h8000, 16'h7FFF, 16'h8000};
        send_triangle(pack_tri(v));
        v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h7FFF, 16'h8000};
        send_triangle(pack_tri(v));
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
              16'h0000, 16'h0100, 16'h0000};
        send_triangle(pack_tri(v));
        v = '{16'h1234, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000,
              16'h1234, 16'hFFFF, 16'h0000};   // all vertices equal: zero length
        send_triangle(pack_tri(v));
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
              16'h0000, 16'h0001, 16'h0000};   // length exactly 1: at threshold
        send_triangle(pack_tri(v));
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0000, 16'h0000,
              16'h0000, 16'h0001, 16'h0000};   // length 2: just above threshold
        send_triangle(pack_tri(v));
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000,
              16'h0000, 16'h0001, 16'h0001};   // floored root 1: at threshold, degenerate
        send_triangle(pack_tri(v));
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'hFFFE, 16'h0001,
              16'hFFFF, 16'h0002, 16'h0005};
        send_triangle(pack_tri(v));
        v = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
              16'hFFFF, 16'h0000, 16'h7FFF};
        send_triangle(pack_tri(v));
        repeat (6) send_triangle(random_tri());
        drain();

        write_min_length(32'd0);
        v = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
              16'h0000, 16'h0001, 16'h0000};
        send_triangle(pack_tri(v));
        drain();
        write_min_length(32'hFFFF_FFFF);
        repeat (40) send_triangle(random_tri());
        drain();
        write_min_length(32'h0100_0000);

        send_idle_pct = 18; recv_idle_pct = 65;
        random_phase(550);
        drain();   // sender holds until every result is back
        write_min_length(32'h0000_4000);

        send_idle_pct = 65; recv_idle_pct = 18;
        random_phase(550);
        drain();
        write_min_length(tun_pkg::MIN_LENGTH_RESET);

        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(550);
        drain();

        $display("sent %0d triangles, checked %0d results (%0d degenerate)",
                 n_sent, normals.n_checked, normals.n_degenerate);
        $display("thresholds 0, 1, 0x4000, 0x1000000 and all ones; three idle patterns");
        if (normals.errors == 0 && normals.pending_q.size() == 0)
            $display("tb_triangle_unit_normal: done, clean");
        else
            $display("tb_triangle_unit_normal: done, errors");
        $finish;
    end
endmodule
